FILE: design/ascs_pkg.sv
// Shared constants, register codes and the lane control bundle for the
// accelerometer calibrate-and-smooth core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ascs_pkg;

	// Default widths of one sample and of the filter fraction
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed register and counter widths
	localparam int CNT_W      = 10;
	localparam int TRIAL_W    = 11;
	localparam int THR_W      = 36;
	localparam int CFG_DATA_W = 36;
	localparam int CFG_IDX_W  = 2;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDED_SAMPLES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIAL_LIMIT     = 2'd3;

	// Reset values of the fixed-width registers
	localparam logic [THR_W-1:0]   THR_RST    = 36'd670761;
	localparam logic [CNT_W-1:0]   NEEDED_RST = 10'd100;
	localparam logic [TRIAL_W-1:0] LIMIT_RST  = 11'd1000;

	// Per-beat control handed to every axis lane
	typedef struct packed {
		logic load;      // sample beat taken, form corrected value
		logic adv2;      // move stage 1 to stage 2
		logic adv3;      // move stage 2 to stage 3
		logic commit;    // update filter, result leaves
		logic ref_load;  // replace the calibration reference
	} lane_ctl_t;

endpackage

`default_nettype wire

FILE: design/accel_still_calibrate_and_smooth_core.sv
// Top level of the accelerometer calibrate-and-smooth core: stream ports,
// configuration registers, three axis lanes and the merge stage.
// Depends on ascs_pkg, ascs_lane, ascs_calib.
`timescale 1ns / 1ps
`default_nettype none

// Each sample beat produces one result beat. A sample passes through three
// pipeline registers in each axis lane (offset removal, filter difference,
// coefficient multiply) and then the filter commit into the output
// register; one sample is in flight at a time, so the core takes no new
// sample until the last one has committed, and the commit waits while the
// output register is still occupied. The sample that completes a successful
// calibration additionally holds off the next sample while the two serial
// dividers form the X/Y offsets. A finished result waits in the output
// register without blocking the next sample. After reset the core
// calibrates: keep the sensor still until m_tuser bit 0 drops.
module accel_still_calibrate_and_smooth_core #(
	parameter int SAMPLE_BITS = ascs_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = ascs_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Sample stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// sample_x, sample_y, sample_z
	input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	// Result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// corrected_x, corrected_y, corrected_z, smooth_x, smooth_y, smooth_z
	output logic [((6*SAMPLE_BITS+5+7)/8)*8-1:0]  m_tdata,
	// calibrating, calib_failed
	output logic [1:0]                            m_tuser,
	// Configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ascs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ascs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int OUT_W  = ((6*SAMPLE_BITS+5+7)/8)*8;
	localparam int PAD_W  = OUT_W - (6*SAMPLE_BITS+5);
	localparam int DSQ_W  = 2 * (SAMPLE_BITS + 2);
	localparam int C_W    = FRAC_BITS + 1;
	localparam logic [C_W-1:0] COEFF_RST = C_W'(((1 << FRAC_BITS) + 5) / 10);

	// Configuration registers
	logic [C_W-1:0]                       coeff_q;
	logic [ascs_pkg::THR_W-1:0]           thr_q;
	logic [ascs_pkg::CNT_W-1:0]           needed_q;
	logic [ascs_pkg::TRIAL_W-1:0]         limit_q;

	// Sequencing
	logic v_s1_q, v_s2_q, v_s3_q;
	logic accept, commit, div_busy;
	ascs_pkg::lane_ctl_t ctl;
	logic ref_load;

	// Output register
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic [1:0]         m_tuser_q;

	// Lane and merge wiring
	logic signed [SB:0]    corr_x, corr_y, corr_z;
	logic signed [SB:0]    smooth_x, smooth_y, smooth_z;
	logic [DSQ_W-1:0]      dsq_x, dsq_y, dsq_z;
	logic signed [SB-1:0]  offset_x, offset_y;
	logic                  calibrating, calib_failed;

	assign cfg_ready = 1'b1;

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q  <= COEFF_RST;
			thr_q    <= ascs_pkg::THR_RST;
			needed_q <= ascs_pkg::NEEDED_RST;
			limit_q  <= ascs_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ascs_pkg::REG_FILTER_COEFF: begin
					coeff_q <= cfg_data[C_W-1:0];
				end
				ascs_pkg::REG_STILL_THRESHOLD: begin
					thr_q <= cfg_data[ascs_pkg::THR_W-1:0];
				end
				ascs_pkg::REG_NEEDED_SAMPLES: begin
					needed_q <= cfg_data[ascs_pkg::CNT_W-1:0];
				end
				ascs_pkg::REG_TRIAL_LIMIT: begin
					limit_q <= cfg_data[ascs_pkg::TRIAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Take a sample only with the lanes empty and the offsets settled
	assign s_tready = !(v_s1_q || v_s2_q || v_s3_q) && !div_busy;
	assign accept   = s_tvalid && s_tready;
	assign commit   = v_s3_q && (!m_tvalid_q || m_tready);

	always_comb begin
		ctl.load     = accept;
		ctl.adv2     = v_s1_q;
		ctl.adv3     = v_s2_q;
		ctl.commit   = commit;
		ctl.ref_load = ref_load;
	end

	// Advance the single sample through the lane stages; hold at the end
	// while the output register is still occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			v_s1_q <= accept;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q || (v_s3_q && !commit);
		end
	end

	ascs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (s_tdata[SB-1:0]),
		.offset (offset_x),
		.coeff  (coeff_q),
		.corr   (corr_x),
		.dsq    (dsq_x),
		.smooth (smooth_x)
	);

	ascs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (s_tdata[2*SB-1:SB]),
		.offset (offset_y),
		.coeff  (coeff_q),
		.corr   (corr_y),
		.dsq    (dsq_y),
		.smooth (smooth_y)
	);

	ascs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (s_tdata[3*SB-1:2*SB]),
		.offset ('0),
		.coeff  (coeff_q),
		.corr   (corr_z),
		.dsq    (dsq_z),
		.smooth (smooth_z)
	);

	ascs_calib #(.SAMPLE_BITS(SAMPLE_BITS)) u_calib (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.corr_x       (corr_x),
		.corr_y       (corr_y),
		.dsq_x        (dsq_x),
		.dsq_y        (dsq_y),
		.dsq_z        (dsq_z),
		.thr          (thr_q),
		.needed       (needed_q),
		.limit        (limit_q),
		.ref_load     (ref_load),
		.calibrating  (calibrating),
		.calib_failed (calib_failed),
		.busy         (div_busy),
		.offset_x     (offset_x),
		.offset_y     (offset_y)
	);

	// Output register: load on commit, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {{PAD_W{1'b0}}, smooth_z, smooth_y, smooth_x,
				corr_z[SB-1:0], corr_y, corr_x};
			m_tuser_q <= {calib_failed, calibrating};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// At most one of the lane stages or the offset division is busy
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1_q, v_s2_q, v_s3_q, div_busy}))
		else $error("more than one sample in flight");

	// Division starts only from the commit of a sample
	a_div_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_busy) |-> $past(v_s3_q))
		else $error("offset division started without a sample");

	// A sample in the lanes never sees the offsets change under it
	a_offsets_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || v_s2_q || v_s3_q) |-> ($stable(offset_x) && $stable(offset_y)))
		else $error("offsets changed while a sample was in the lanes");

endmodule

`default_nettype wire

FILE: design/ascs_lane.sv
// One axis lane: offset removal, exponential filter update and squared
// distance from the calibration reference. Depends on ascs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ascs_lane #(
	parameter int SAMPLE_BITS = ascs_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = ascs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ascs_pkg::lane_ctl_t               ctl,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic signed [SAMPLE_BITS-1:0]     offset,
	input  logic        [FRAC_BITS:0]         coeff,
	output logic signed [SAMPLE_BITS:0]       corr,
	output logic        [2*(SAMPLE_BITS+2)-1:0] dsq,
	output logic signed [SAMPLE_BITS:0]       smooth
);

	localparam int CORR_W = SAMPLE_BITS + 1;
	localparam int FILT_W = SAMPLE_BITS + 1 + FRAC_BITS;
	localparam int DIFF_W = FILT_W + 1;
	localparam int DH_W   = DIFF_W - FRAC_BITS;
	localparam int C_W    = FRAC_BITS + 1;
	localparam int PH_W   = DH_W + C_W + 1;
	localparam int PL_W   = FRAC_BITS + C_W;
	localparam int R_W    = PH_W + 1;
	localparam int DREF_W = SAMPLE_BITS + 2;
	localparam int DSQ_W  = 2 * DREF_W;

	localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
	localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};

	logic signed [FILT_W-1:0] filt_q;
	logic signed [CORR_W-1:0] ref_q;

	logic signed [CORR_W-1:0] corr_s1, corr_s2, corr_s3;
	logic signed [DH_W-1:0]   dh_s2;
	logic [FRAC_BITS-1:0]     dl_s2;
	logic signed [DREF_W-1:0] dref_s2;
	logic signed [PH_W-1:0]   ph_s3;
	logic [C_W-1:0]           pl_s3;
	logic [DSQ_W-1:0]         dsq_s3;

	logic signed [DIFF_W-1:0] target, diff;
	logic signed [DREF_W-1:0] dref;
	logic signed [C_W:0]      coeff_s;
	logic signed [PH_W-1:0]   ph;
	logic [PL_W-1:0]          pl_full;
	logic signed [DSQ_W-1:0]  dsq_full;
	logic signed [R_W-1:0]    r;
	logic [R_W-FILT_W:0]      r_top;
	logic signed [FILT_W-1:0] filt_n;

	// Stage 2 terms: distance to target in Q.FRAC, distance to reference
	assign target = $signed({corr_s1[CORR_W-1], corr_s1, {FRAC_BITS{1'b0}}});
	assign diff   = target - DIFF_W'(filt_q);
	assign dref   = DREF_W'(ref_q) - DREF_W'(corr_s1);

	// Stage 3 products: coefficient split over the high and low parts of diff
	assign coeff_s  = $signed({1'b0, coeff});
	assign ph       = dh_s2 * coeff_s;
	assign pl_full  = dl_s2 * coeff;
	assign dsq_full = dref_s2 * dref_s2;

	// Commit: add the step and clamp to the filter width
	assign r      = R_W'(filt_q) + R_W'(ph_s3) + $signed({{(R_W-C_W){1'b0}}, pl_s3});
	assign r_top  = r[R_W-1:FILT_W-1];
	always_comb begin
		if ((&r_top) || !(|r_top)) begin
			filt_n = r[FILT_W-1:0];
		end else if (r[R_W-1]) begin
			filt_n = FILT_MIN;
		end else begin
			filt_n = FILT_MAX;
		end
	end

	// Payload stages, advanced by the top-level sequencing
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			corr_s1 <= CORR_W'(sample) - CORR_W'(offset);
		end
		if (ctl.adv2) begin
			corr_s2 <= corr_s1;
			dh_s2   <= diff[DIFF_W-1:FRAC_BITS];
			dl_s2   <= diff[FRAC_BITS-1:0];
			dref_s2 <= dref;
		end
		if (ctl.adv3) begin
			corr_s3 <= corr_s2;
			ph_s3   <= ph;
			pl_s3   <= pl_full[PL_W-1:FRAC_BITS];
			dsq_s3  <= dsq_full;
		end
	end

	// Filter state and calibration reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			ref_q  <= '0;
		end else begin
			if (ctl.commit) begin
				filt_q <= filt_n;
			end
			if (ctl.ref_load) begin
				ref_q <= corr_s3;
			end
		end
	end

	assign corr   = corr_s3;
	assign dsq    = dsq_s3;
	assign smooth = filt_n[FILT_W-1:FRAC_BITS];

endmodule

`default_nettype wire

FILE: design/ascs_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, result
// truncated toward zero. Depends on ascs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ascs_div #(
	parameter int SAMPLE_BITS = ascs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic signed [SAMPLE_BITS+ascs_pkg::CNT_W-1:0] dividend,
	input  logic        [ascs_pkg::CNT_W-1:0]          divisor,
	output logic                                       busy,
	output logic                                       done,
	output logic signed [SAMPLE_BITS-1:0]              quotient
);

	localparam int SUM_W  = SAMPLE_BITS + ascs_pkg::CNT_W;
	localparam int CNT_W  = ascs_pkg::CNT_W;
	localparam int STEP_W = $clog2(SUM_W);

	logic                busy_q, fin_q, neg_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q, den_q;

	logic [SUM_W-1:0]    mag;
	logic [CNT_W:0]      trial, rem_n;
	logic                ge;
	logic [SUM_W-1:0]    res;

	// Restoring step on the magnitude
	assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_n = ge ? trial - {1'b0, den_q} : trial;
	assign res   = neg_q ? -quo_q : quo_q;

	// Control: count the steps, then flag done to hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == STEP_W'(SUM_W-1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Datapath: shift quotient bits in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign busy     = busy_q | fin_q;
	assign done     = fin_q;
	assign quotient = res[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

FILE: design/ascs_calib.sv
// Merge stage: adds the lane distances, runs the still-detection
// calibration and holds the X/Y offsets. Depends on ascs_pkg and ascs_div.
`timescale 1ns / 1ps
`default_nettype none

module ascs_calib #(
	parameter int SAMPLE_BITS = ascs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   commit,
	input  logic signed [SAMPLE_BITS:0]            corr_x,
	input  logic signed [SAMPLE_BITS:0]            corr_y,
	input  logic        [2*(SAMPLE_BITS+2)-1:0]    dsq_x,
	input  logic        [2*(SAMPLE_BITS+2)-1:0]    dsq_y,
	input  logic        [2*(SAMPLE_BITS+2)-1:0]    dsq_z,
	input  logic        [ascs_pkg::THR_W-1:0]      thr,
	input  logic        [ascs_pkg::CNT_W-1:0]      needed,
	input  logic        [ascs_pkg::TRIAL_W-1:0]    limit,
	output logic                                   ref_load,
	output logic                                   calibrating,
	output logic                                   calib_failed,
	output logic                                   busy,
	output logic signed [SAMPLE_BITS-1:0]          offset_x,
	output logic signed [SAMPLE_BITS-1:0]          offset_y
);

	localparam int CNT_W   = ascs_pkg::CNT_W;
	localparam int TRIAL_W = ascs_pkg::TRIAL_W;
	localparam int THR_W   = ascs_pkg::THR_W;
	localparam int SUM_W   = SAMPLE_BITS + CNT_W;
	localparam int DSQ_W   = 2 * (SAMPLE_BITS + 2);
	localparam int D2_W    = DSQ_W + 2;
	localparam int CMP_W   = (D2_W > THR_W) ? D2_W : THR_W;

	logic                     have_ref_q, calib_q, failed_q;
	logic [TRIAL_W-1:0]       trial_q;
	logic [CNT_W-1:0]         still_q;
	logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
	logic signed [SAMPLE_BITS-1:0] offset_x_q, offset_y_q;

	logic [D2_W-1:0]          d2;
	logic                     still, trial_fire, done_ok, done_fail, div_start;
	logic [TRIAL_W-1:0]       trial_n;
	logic [CNT_W-1:0]         still_n;
	logic signed [SUM_W-1:0]  sum_x_n, sum_y_n;

	logic                     busy_x, busy_y, done_x, done_y;
	logic signed [SAMPLE_BITS-1:0] quo_x, quo_y;

	// Distance test and counter updates for one trial
	always_comb begin
		d2         = D2_W'(dsq_x) + D2_W'(dsq_y) + D2_W'(dsq_z);
		still      = CMP_W'(d2) < CMP_W'(thr);
		trial_n    = (&trial_q) ? trial_q : trial_q + 1'b1;
		still_n    = (still && !(&still_q)) ? still_q + 1'b1 : still_q;
		sum_x_n    = still ? sum_x_q + SUM_W'(corr_x) : sum_x_q;
		sum_y_n    = still ? sum_y_q + SUM_W'(corr_y) : sum_y_q;
		trial_fire = commit && calib_q && have_ref_q;
		done_ok    = still_n >= needed;
		done_fail  = !done_ok && (trial_n >= limit);
		div_start  = trial_fire && done_ok && (still_n != '0);
		ref_load   = commit && calib_q && (!have_ref_q || still);
	end

	// Calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_ref_q <= 1'b0;
			calib_q    <= 1'b1;
			failed_q   <= 1'b0;
			trial_q    <= '0;
			still_q    <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else begin
			if (commit && calib_q && !have_ref_q) begin
				have_ref_q <= 1'b1;
			end
			if (trial_fire) begin
				trial_q <= trial_n;
				still_q <= still_n;
				sum_x_q <= sum_x_n;
				sum_y_q <= sum_y_n;
				if (done_ok) begin
					calib_q  <= 1'b0;
					failed_q <= 1'b0;
					if (still_n == '0) begin
						offset_x_q <= '0;
						offset_y_q <= '0;
					end
				end else if (done_fail) begin
					calib_q    <= 1'b0;
					failed_q   <= 1'b1;
					offset_x_q <= '0;
					offset_y_q <= '0;
				end
			end
			// Take the averaged offsets when the dividers finish
			if (done_x) begin
				offset_x_q <= quo_x;
			end
			if (done_y) begin
				offset_y_q <= quo_y;
			end
		end
	end

	ascs_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_x_n),
		.divisor  (still_n),
		.busy     (busy_x),
		.done     (done_x),
		.quotient (quo_x)
	);

	ascs_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_y_n),
		.divisor  (still_n),
		.busy     (busy_y),
		.done     (done_y),
		.quotient (quo_y)
	);

	assign calibrating  = calib_q && !(trial_fire && (done_ok || done_fail));
	assign calib_failed = failed_q || (trial_fire && done_fail);
	assign busy         = busy_x;
	assign offset_x     = offset_x_q;
	assign offset_y     = offset_y_q;

	// Offsets are only averaged once calibration has closed
	a_div_after_calib: assert property (@(posedge clk) disable iff (!arst_n)
		busy_x |-> !calib_q) else $error("divider runs during calibration");

	a_fail_closes: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> !calib_q) else $error("failure flag set while calibrating");

	a_still_le_trial: assert property (@(posedge clk) disable iff (!arst_n)
		TRIAL_W'(still_q) <= trial_q)
		else $error("still count exceeds trial count");

	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		busy_x == busy_y) else $error("X and Y dividers out of step");

endmodule

`default_nettype wire

FILE: sim/accel_still_calibrate_and_smooth_core_tb.sv
// Self-checking testbench for the accelerometer calibrate-and-smooth core:
// runs calibration once after reset, then random sample streams under several
// register settings. Depends on ascs_pkg and accel_still_calibrate_and_smooth_core.
`timescale 1ns / 1ps

module accel_still_calibrate_and_smooth_core_tb;

	localparam int SB = ascs_pkg::SAMPLE_BITS_DEF;
	localparam int FB = ascs_pkg::FRAC_BITS_DEF;
	localparam int TRIAL_W = ascs_pkg::TRIAL_W;
	localparam int CNT_W = ascs_pkg::CNT_W;
	localparam int THR_W = ascs_pkg::THR_W;
	localparam int CFG_IDX_W = ascs_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = ascs_pkg::CFG_DATA_W;
	localparam int S_W = ((3*SB+7)/8)*8;
	localparam int M_W = ((6*SB+5+7)/8)*8;
	localparam longint COEFF_RST = 6554;
	localparam longint THR_RST = longint'(ascs_pkg::THR_RST);
	localparam int NEEDED_RST = int'(ascs_pkg::NEEDED_RST);
	localparam int LIMIT_RST = int'(ascs_pkg::LIMIT_RST);
	localparam int TRIAL_MAX = (1 << TRIAL_W) - 1;
	localparam int STILL_MAX = (1 << CNT_W) - 1;
	localparam longint FILT_HI = (longint'(1) <<< (SB+FB)) - 1;
	localparam longint FILT_LO = -FILT_HI - 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_AT = 250;
	localparam int HOLD_LEN = 80;
	localparam int PHASE_ITEMS = 140;

	typedef struct packed {
		logic signed [SB-1:0] x;
		logic signed [SB-1:0] y;
		logic signed [SB-1:0] z;
	} accel_t;

	typedef struct {
		logic signed [SB:0]   cor_x;
		logic signed [SB:0]   cor_y;
		logic signed [SB-1:0] cor_z;
		logic signed [SB:0]   avg_x;
		logic signed [SB:0]   avg_y;
		logic signed [SB:0]   avg_z;
		logic                 calibrating;
		logic                 failed;
	} filtered_t;

	typedef enum int {CAL_STEADY, CAL_RESTLESS, CAL_SINGLE, CAL_ALL_STILL} cal_plan_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_W-1:0]       s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_W-1:0]       m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	accel_still_calibrate_and_smooth_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the core: registers, offsets, filters and calibration state
	longint coeff = COEFF_RST;
	longint thresh = THR_RST;
	int     need_n = NEEDED_RST;
	int     limit_n = LIMIT_RST;
	longint ofs_x = 0, ofs_y = 0;
	longint filt[3] = '{0, 0, 0};
	longint anchor_pt[3] = '{0, 0, 0};
	longint sum_x = 0, sum_y = 0;
	int     still_n = 0, trial_n = 0;
	bit     have_anchor = 1'b0;
	bit     calib_on = 1'b1;
	bit     calib_bad = 1'b0;

	filtered_t corrected_q[$];
	accel_t    sample_q[$];

	// Handshake bookkeeping, updated at the rising edge
	bit s_fire = 1'b0, c_fire = 1'b0, m_fire = 1'b0;
	int pushed_n = 0, accepted_n = 0, checked_n = 0;
	int mismatches = 0;
	int quiet_n = 0;

	// Sender and receiver pacing
	int s_gap = 0, m_gap = 0, m_hold = 0;
	bit s_burst = 1'b0, m_burst = 1'b0;
	bit hold_done = 1'b0;

	// One filter update: move toward the target by coeff/2^FB of the difference
	function automatic longint ema_next(longint f, longint c);
		longint diff, dh, dl, r;
		diff = (c <<< FB) - f;
		dh = diff >>> FB;
		dl = diff & ((longint'(1) <<< FB) - 1);
		r = f + dh * coeff + ((dl * coeff) >>> FB);
		if (r > FILT_HI) r = FILT_HI;
		if (r < FILT_LO) r = FILT_LO;
		return r;
	endfunction

	// Correct, filter and advance calibration for one accepted beat
	task automatic correct_and_filter(input logic [S_W-1:0] beat);
		longint smp[3], cor[3];
		longint d2, dd;
		filtered_t r;
		for (int i = 0; i < 3; i++)
			smp[i] = longint'($signed(beat[i*SB +: SB]));
		cor[0] = smp[0] - ofs_x;
		cor[1] = smp[1] - ofs_y;
		cor[2] = smp[2];
		for (int i = 0; i < 3; i++)
			filt[i] = ema_next(filt[i], cor[i]);

		if (calib_on) begin
			if (!have_anchor) begin
				for (int i = 0; i < 3; i++)
					anchor_pt[i] = cor[i];
				have_anchor = 1'b1;
			end else begin
				if (trial_n < TRIAL_MAX)
					trial_n++;
				d2 = 0;
				for (int i = 0; i < 3; i++) begin
					dd = anchor_pt[i] - cor[i];
					d2 += dd * dd;
				end
				// still sample: move the anchor and accumulate
				if (d2 < thresh) begin
					sum_x += cor[0];
					sum_y += cor[1];
					for (int i = 0; i < 3; i++)
						anchor_pt[i] = cor[i];
					if (still_n < STILL_MAX)
						still_n++;
				end
				// enough still samples wins over the trial limit
				if (still_n >= need_n) begin
					if (still_n > 0) begin
						ofs_x = sum_x / longint'(still_n);
						ofs_y = sum_y / longint'(still_n);
					end else begin
						ofs_x = 0;
						ofs_y = 0;
					end
					calib_on = 1'b0;
					calib_bad = 1'b0;
				end else if (trial_n >= limit_n) begin
					ofs_x = 0;
					ofs_y = 0;
					calib_on = 1'b0;
					calib_bad = 1'b1;
				end
			end
		end

		r.cor_x = (SB+1)'(cor[0]);
		r.cor_y = (SB+1)'(cor[1]);
		r.cor_z = SB'(cor[2]);
		r.avg_x = (SB+1)'(filt[0] >>> FB);
		r.avg_y = (SB+1)'(filt[1] >>> FB);
		r.avg_z = (SB+1)'(filt[2] >>> FB);
		r.calibrating = calib_on;
		r.failed = calib_bad;
		corrected_q.push_back(r);
	endtask

	function automatic void check_field(string name, longint want, longint got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Sample handshakes at the rising edge: mirror, check, watchdog
	always @(posedge clk) begin : edge_monitor
		filtered_t e;
		s_fire = arst_n && s_tvalid && s_tready;
		c_fire = arst_n && cfg_valid && cfg_ready;
		m_fire = arst_n && m_tvalid && m_tready;

		if (c_fire) begin
			case (cfg_index)
				ascs_pkg::REG_FILTER_COEFF:    coeff = longint'(cfg_data[FB:0]);
				ascs_pkg::REG_STILL_THRESHOLD: thresh = longint'(cfg_data[THR_W-1:0]);
				ascs_pkg::REG_NEEDED_SAMPLES:  need_n = int'(cfg_data[CNT_W-1:0]);
				ascs_pkg::REG_TRIAL_LIMIT:     limit_n = int'(cfg_data[TRIAL_W-1:0]);
				default: ;
			endcase
		end

		if (s_fire) begin
			correct_and_filter(s_tdata);
			accepted_n++;
		end

		if (m_fire) begin
			if (corrected_q.size() == 0) begin
				$error("result beat with no sample pending");
				mismatches++;
			end else begin
				e = corrected_q.pop_front();
				check_field("corrected_x", longint'(e.cor_x),
					longint'($signed(m_tdata[SB:0])));
				check_field("corrected_y", longint'(e.cor_y),
					longint'($signed(m_tdata[2*SB+1:SB+1])));
				check_field("corrected_z", longint'(e.cor_z),
					longint'($signed(m_tdata[3*SB+1:2*SB+2])));
				check_field("smooth_x", longint'(e.avg_x),
					longint'($signed(m_tdata[4*SB+2:3*SB+2])));
				check_field("smooth_y", longint'(e.avg_y),
					longint'($signed(m_tdata[5*SB+3:4*SB+3])));
				check_field("smooth_z", longint'(e.avg_z),
					longint'($signed(m_tdata[6*SB+4:5*SB+4])));
				check_field("calibrating", longint'(e.calibrating), longint'(m_tuser[0]));
				check_field("calib_failed", longint'(e.failed), longint'(m_tuser[1]));
			end
			checked_n++;
		end

		// Abort when nothing moves for too long
		if (s_fire || c_fire || m_fire)
			quiet_n = 0;
		else
			quiet_n++;
		if (quiet_n >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Drive sample beats at the falling edge, with random gaps between them
	always @(negedge clk) begin : sample_source
		logic nv;
		logic [S_W-1:0] word;
		accel_t a;
		nv = s_tvalid && !s_fire;
		if (arst_n && !nv) begin
			if (s_gap > 0) begin
				s_gap--;
			end else if (sample_q.size() > 0) begin
				a = sample_q.pop_front();
				word = '0;
				word[SB-1:0] = a.x;
				word[2*SB-1:SB] = a.y;
				word[3*SB-1:2*SB] = a.z;
				s_tdata <= word;
				nv = 1'b1;
				s_gap = s_burst ? 0 : int'($urandom_range(0, 3));
				if ($urandom_range(0, 15) == 0)
					s_burst = !s_burst;
			end
		end
		s_tvalid <= nv;
	end

	// Accept result beats with random stalls and one long hold-off while the
	// sender still has plenty queued
	always @(negedge clk) begin : result_sink
		if (m_fire) begin
			if (!hold_done && checked_n >= HOLD_AT && sample_q.size() > 8) begin
				m_hold = HOLD_LEN;
				hold_done = 1'b1;
			end
			m_gap = m_burst ? 0 : int'($urandom_range(0, 3));
			if ($urandom_range(0, 15) == 0)
				m_burst = !m_burst;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (m_hold > 0) begin
			m_hold--;
			m_tready <= 1'b0;
		end else if (m_gap > 0) begin
			m_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_sample(input int x, input int y, input int z);
		accel_t a;
		a.x = SB'(x);
		a.y = SB'(y);
		a.z = SB'(z);
		sample_q.push_back(a);
		pushed_n++;
	endtask

	function automatic int any_val();
		logic signed [SB-1:0] t;
		t = SB'($urandom);
		return int'(t);
	endfunction

	// Random step around v, clamped to the sample range
	function automatic int wander(input int v, input int j);
		int n;
		n = v + int'($urandom_range(0, 2*j)) - j;
		if (n > 32767) n = 32767;
		if (n < -32768) n = -32768;
		return n;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(negedge clk); while (!c_fire);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input longint coef, input longint thr, input int need,
			input int lim);
		write_reg(ascs_pkg::REG_FILTER_COEFF, coef);
		write_reg(ascs_pkg::REG_STILL_THRESHOLD, thr);
		write_reg(ascs_pkg::REG_NEEDED_SAMPLES, longint'(need));
		write_reg(ascs_pkg::REG_TRIAL_LIMIT, longint'(lim));
	endtask

	// Wait until every sample has its result, then let the core go quiet
	task automatic settle();
		while (checked_n < pushed_n)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	initial begin : stimulus
		cal_plan_e plan;
		int jit, need, lim, guard, bx, by, bz, k;
		longint thr;
		longint coef_tbl[5], thr_tbl[5];
		int need_tbl[5], lim_tbl[5];

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset register values: anchor at the corners, then far jumps and a near pair
		push_sample(-32768, 32767, -32768);
		push_sample(32767, -32768, 32767);
		push_sample(0, 0, 0);
		push_sample(-1, -1, -1);
		settle();

		// Pick how calibration should go this run
		plan = cal_plan_e'($urandom_range(0, 3));
		jit = 40;
		case (plan)
			CAL_STEADY: begin
				jit = int'($urandom_range(1, 300));
				thr = longint'(jit) * jit * longint'($urandom_range(1, 12));
				need = still_n + int'($urandom_range(2, 40));
				lim = trial_n + need + int'($urandom_range(0, 60));
			end
			CAL_RESTLESS: begin
				thr = 0;
				need = STILL_MAX;
				lim = trial_n + int'($urandom_range(1, 40));
			end
			CAL_SINGLE: begin
				jit = int'($urandom_range(1, 500));
				thr = longint'($urandom_range(0, 1000000));
				need = 1;
				lim = 1;
			end
			default: begin
				// every trial still; both ends land on the same sample
				thr = (longint'(1) <<< THR_W) - 1;
				need = still_n + int'($urandom_range(10, 60));
				lim = need + (trial_n - still_n);
			end
		endcase
		set_regs(longint'($urandom_range(0, 65536)), thr, need, lim);

		// Calibration: wander near a point with rare outliers (all random in CAL_ALL_STILL)
		bx = any_val();
		by = any_val();
		bz = any_val();
		guard = 0;
		while (calib_on && guard < 400) begin
			if (plan == CAL_ALL_STILL || $urandom_range(0, 9) == 0) begin
				push_sample(any_val(), any_val(), any_val());
			end else begin
				bx = wander(bx, jit);
				by = wander(by, jit);
				bz = wander(bz, jit);
				push_sample(bx, by, bz);
			end
			guard++;
			while (pushed_n - accepted_n >= 2)
				@(negedge clk);
		end
		settle();

		// Register settings for the free-running phases, extremes first
		coef_tbl = '{65536, 0, 1, 0, COEFF_RST};
		coef_tbl[3] = longint'($urandom_range(0, 65536));
		thr_tbl = '{(longint'(1) <<< THR_W) - 1, 0, 0, THR_RST, 0};
		thr_tbl[2] = longint'($urandom) * longint'($urandom_range(1, 16));
		thr_tbl[4] = longint'($urandom_range(0, 1000000));
		need_tbl = '{STILL_MAX, 1, 0, NEEDED_RST, 0};
		need_tbl[2] = int'($urandom_range(1, STILL_MAX));
		need_tbl[4] = int'($urandom_range(1, STILL_MAX));
		lim_tbl = '{TRIAL_MAX, 1, 0, LIMIT_RST, 0};
		lim_tbl[2] = int'($urandom_range(1, TRIAL_MAX));
		lim_tbl[4] = int'($urandom_range(1, TRIAL_MAX));

		for (int p = 0; p < 5; p++) begin
			set_regs(coef_tbl[p], thr_tbl[p], need_tbl[p], lim_tbl[p]);
			if (p == 0) begin
				// every corner of the sample cube, zero and alternating bits
				for (int m = 0; m < 8; m++)
					push_sample(m[0] ? 32767 : -32768, m[1] ? 32767 : -32768,
						m[2] ? 32767 : -32768);
				push_sample(0, 0, 0);
				push_sample(21845, -21846, 21845);
				push_sample(-21846, 21845, -21846);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				k = int'($urandom_range(0, 2));
				if (k == 0) begin
					push_sample(any_val(), any_val(), any_val());
				end else if (k == 1) begin
					bx = wander(bx, 2000);
					by = wander(by, 2000);
					bz = wander(bz, 2000);
					push_sample(bx, by, bz);
				end else begin
					push_sample(int'($urandom_range(0, 8)) - 4,
						int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4);
				end
			end
			settle();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0 && corrected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
